>>> hdl/g711c_pkg.sv
`default_nettype none
package g711c_pkg;

	// mode register codes
	localparam logic [2:0] MODE_LIN2A  = 3'd0;
	localparam logic [2:0] MODE_A2LIN  = 3'd1;
	localparam logic [2:0] MODE_LIN2MU = 3'd2;
	localparam logic [2:0] MODE_MU2LIN = 3'd3;
	localparam logic [2:0] MODE_A2MU   = 3'd4;
	localparam logic [2:0] MODE_MU2A   = 3'd5;

	// companding constants
	localparam logic [15:0] ALAW_LOW_MASK  = 16'hFFF8;
	localparam logic [15:0] MULAW_LOW_MASK = 16'hFFFC;
	localparam logic [15:0] MULAW_CLIP     = 16'd32636;
	localparam logic [15:0] MULAW_BIAS     = 16'h0084;
	localparam logic [15:0] ALAW_SEG1_OFS  = 16'h0108;
	localparam logic [15:0] ALAW_SEG0_OFS  = 16'h0008;
	localparam logic [7:0]  ALAW_MASK_POS  = 8'hD5;
	localparam logic [7:0]  ALAW_MASK_NEG  = 8'h55;
	localparam logic [7:0]  MULAW_MASK_POS = 8'hFF;
	localparam logic [7:0]  MULAW_MASK_NEG = 8'h7F;
	localparam logic [6:0]  CODE_OVF       = 7'h7F;
	localparam logic [15:0] SEG_BASE       = 16'h0100;
	localparam int          SEG_COUNT      = 8;

	// standard a-law to mu-law translation
	localparam logic [7:0] A2MU_TAB [128] = '{
		8'd1,   8'd3,   8'd5,   8'd7,   8'd9,   8'd11,  8'd13,  8'd15,
		8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,
		8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd31,
		8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd34,  8'd35,  8'd35,
		8'd36,  8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
		8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd48,  8'd49,  8'd49,
		8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,
		8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd64,
		8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,
		8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd80,
		8'd80,  8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,
		8'd88,  8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,
		8'd96,  8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103,
		8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111,
		8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
		8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127
	};

	// standard mu-law to a-law translation
	localparam logic [7:0] MU2A_TAB [128] = '{
		8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd4,
		8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,
		8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,
		8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,
		8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd34,  8'd35,  8'd36,
		8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,
		8'd46,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
		8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
		8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,
		8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
		8'd80,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,
		8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,  8'd96,
		8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
		8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
		8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
		8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128
	};

	typedef struct packed {
		logic signed [15:0] pcm_in;
		logic [7:0]         code_in;
		logic               last_in;
	} g711_in_t;

	typedef struct packed {
		logic signed [15:0] pcm_out;
		logic [7:0]         code_out;
		logic               last_out;
	} g711_out_t;

	// after stage 1: encoder magnitude or prepared code byte
	typedef struct packed {
		logic [2:0]  mode;
		logic        last;
		logic        neg;
		logic [15:0] mag;
		logic [7:0]  cbyte;
	} g711_s1_t;

	// after stage 2: segment coded or decoded magnitude
	typedef struct packed {
		logic [2:0]  mode;
		logic        last;
		logic        neg;
		logic [15:0] mag;
		logic [7:0]  code;
	} g711_s2_t;

endpackage
`default_nettype wire

>>> hdl/g711c_prep.sv
`default_nettype none
module g711c_prep (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  wire [2:0]              mode,
	input  g711c_pkg::g711_in_t    req,
	output logic                   valid_s1,
	output g711c_pkg::g711_s1_t    data_s1
);
	import g711c_pkg::*;

	logic [15:0] raw;
	logic [15:0] m_a;
	logic [15:0] m_u;
	logic [15:0] mag_a;
	logic [15:0] mag_u_raw;
	logic [15:0] mag_u_clip;
	logic [6:0]  tidx;
	logic [7:0]  mu2a_m1;
	g711_s1_t    nxt;

	// sample masking, magnitude, clip and mu-to-a table lookup
	always_comb begin
		raw = $unsigned(req.pcm_in);
		m_a = raw & ALAW_LOW_MASK;
		m_u = raw & MULAW_LOW_MASK;
		mag_a = m_a[15] ? 16'(17'h10000 - {1'b0, m_a} - 17'd8) : m_a;
		mag_u_raw = m_u[15] ? 16'(17'h10000 - {1'b0, m_u}) : m_u;
		mag_u_clip = (mag_u_raw > MULAW_CLIP) ? MULAW_CLIP : mag_u_raw;
		tidx = ~req.code_in[6:0];
		mu2a_m1 = MU2A_TAB[tidx] - 8'd1;
	end

	// per-mode preparation
	always_comb begin
		nxt.mode = mode;
		nxt.last = req.last_in;
		nxt.neg = raw[15];
		nxt.mag = '0;
		nxt.cbyte = '0;
		case (mode)
			MODE_LIN2A: begin
				nxt.mag = mag_a;
			end
			MODE_LIN2MU: begin
				nxt.mag = mag_u_clip + MULAW_BIAS;
			end
			MODE_A2LIN: begin
				nxt.cbyte = req.code_in ^ ALAW_MASK_NEG;
			end
			MODE_MU2LIN: begin
				nxt.cbyte = ~req.code_in;
			end
			MODE_A2MU: begin
				if (req.code_in[7]) begin
					nxt.cbyte = MULAW_MASK_POS ^ A2MU_TAB[7'(req.code_in ^ ALAW_MASK_POS)];
				end else begin
					nxt.cbyte = MULAW_MASK_NEG ^ A2MU_TAB[7'(req.code_in ^ ALAW_MASK_NEG)];
				end
			end
			MODE_MU2A: begin
				if (req.code_in[7]) begin
					nxt.cbyte = ALAW_MASK_POS ^ mu2a_m1;
				end else begin
					nxt.cbyte = ALAW_MASK_NEG ^ mu2a_m1;
				end
			end
			default: begin
				nxt.cbyte = '0;
			end
		endcase
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> hdl/g711c_core.sv
`default_nettype none
module g711c_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    valid_s1,
	input  g711c_pkg::g711_s1_t    data_s1,
	output logic                   valid_s2,
	output g711c_pkg::g711_s2_t    data_s2
);
	import g711c_pkg::*;

	logic [3:0]  seg;
	logic [3:0]  sh;
	logic [3:0]  mant;
	logic [6:0]  code_a;
	logic [6:0]  code_u;
	logic [2:0]  aseg;
	logic [15:0] at;
	logic [15:0] amag;
	logic [15:0] ut;
	g711_s2_t    nxt;

	// segment priority search over the encoder magnitude
	always_comb begin
		seg = 4'(SEG_COUNT);
		for (int s = SEG_COUNT - 1; s >= 0; s--) begin
			if (data_s1.mag < (SEG_BASE << s)) begin
				seg = 4'(s);
			end
		end
		sh = {1'b0, seg[2:0]} + 4'd3;
		mant = 4'(data_s1.mag >> sh);
	end

	// encoder code assembly
	always_comb begin
		if (seg[3]) begin
			code_a = CODE_OVF;
		end else if (seg < 4'd2) begin
			code_a = {seg[2:0], data_s1.mag[7:4]};
		end else begin
			code_a = {seg[2:0], mant};
		end
		if (seg[3]) begin
			code_u = CODE_OVF;
		end else begin
			code_u = {seg[2:0], mant};
		end
	end

	// decoder magnitudes
	always_comb begin
		aseg = data_s1.cbyte[6:4];
		at = {8'd0, data_s1.cbyte[3:0], 4'd0};
		case (aseg)
			3'd0: amag = at + ALAW_SEG0_OFS;
			3'd1: amag = at + ALAW_SEG1_OFS;
			default: amag = 16'((at + ALAW_SEG1_OFS) << (aseg - 3'd1));
		endcase
		ut = 16'(({9'd0, data_s1.cbyte[3:0], 3'd0} + MULAW_BIAS) << data_s1.cbyte[6:4]);
	end

	always_comb begin
		nxt.mode = data_s1.mode;
		nxt.last = data_s1.last;
		nxt.neg = data_s1.neg;
		nxt.mag = '0;
		nxt.code = '0;
		case (data_s1.mode)
			MODE_LIN2A: begin
				nxt.code = {1'b0, code_a};
			end
			MODE_LIN2MU: begin
				nxt.code = {1'b0, code_u};
			end
			MODE_A2LIN: begin
				nxt.neg = ~data_s1.cbyte[7];
				nxt.mag = amag;
			end
			MODE_MU2LIN: begin
				nxt.neg = data_s1.cbyte[7];
				nxt.mag = ut - MULAW_BIAS;
			end
			MODE_A2MU, MODE_MU2A: begin
				nxt.code = data_s1.cbyte;
			end
			default: begin
				nxt.code = '0;
			end
		endcase
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> hdl/g711c_out.sv
`default_nettype none
module g711c_out (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    valid_s2,
	input  g711c_pkg::g711_s2_t    data_s2,
	output logic                   done,
	output g711c_pkg::g711_out_t   rsp
);
	import g711c_pkg::*;

	g711_out_t   nxt;
	logic [15:0] lin;

	// sign and transmit masks
	always_comb begin
		lin = data_s2.neg ? 16'(17'h10000 - {1'b0, data_s2.mag}) : data_s2.mag;
		nxt.last_out = data_s2.last;
		nxt.pcm_out = '0;
		nxt.code_out = '0;
		case (data_s2.mode)
			MODE_LIN2A: begin
				nxt.code_out = data_s2.code ^ (data_s2.neg ? ALAW_MASK_NEG : ALAW_MASK_POS);
			end
			MODE_LIN2MU: begin
				nxt.code_out = data_s2.code ^ (data_s2.neg ? MULAW_MASK_NEG : MULAW_MASK_POS);
			end
			MODE_A2LIN, MODE_MU2LIN: begin
				nxt.pcm_out = $signed(lin);
			end
			MODE_A2MU, MODE_MU2A: begin
				nxt.code_out = data_s2.code;
			end
			default: begin
				nxt.code_out = '0;
			end
		endcase
	end

	// stage 3 output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			rsp <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> hdl/g711_companding_codec_top.sv
// a request passes the prepare and segment stage registers, then done and rsp load
// from the output stage register
// throughput: one request per cycle; busy stays low, three register stages
// (prepare, segment code/decode, sign mask) each hold one request
// the result is shown for one cycle only and cannot be stalled by the receiver
// reset: arst_n clears the stage valid bits and sets mode to linear to a-law
`default_nettype none
module g711_companding_codec_top (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  g711c_pkg::g711_in_t    req,
	input  wire                    cfg_we,
	input  wire [2:0]              cfg_wdata,
	output logic                   done,
	output g711c_pkg::g711_out_t   rsp
);
	import g711c_pkg::*;

	logic       mode_q;
	logic [2:0] mode_val_q;
	logic       accept;
	logic       valid_s1;
	logic       valid_s2;
	g711_s1_t   data_s1;
	g711_s2_t   data_s2;

	assign busy = 1'b0;
	assign accept = start & ~busy;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_val_q <= MODE_LIN2A;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_val_q <= cfg_wdata;
			mode_q <= 1'b1;
		end
	end

	g711c_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.mode     (mode_val_q),
		.req      (req),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	g711c_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	g711c_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.done     (done),
		.rsp      (rsp)
	);

	// a result only follows an accepted request
	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result without request");

	// last flag travels with its request
	a_last_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.last_out == $past(req.last_in, 3)))
		else $error("last flag lost");

	// decoded magnitudes never exceed the top segment value
	a_dec_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (data_s2.mode == MODE_A2LIN || data_s2.mode == MODE_MU2LIN))
		|-> (data_s2.mag <= 16'h7E00))
		else $error("decoded magnitude out of range");

	// mode writes take effect; register was loaded or still at reset value
	a_mode_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!mode_q |-> (mode_val_q == MODE_LIN2A))
		else $error("mode changed without a write");

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
module tb;
	import g711c_pkg::*;

	// mode values the block treats as unused
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	localparam int STALL_LIMIT = 200;
	localparam int PRINT_CAP   = 50;

	// a-law to mu-law translation, corrected entry 79
	localparam logic [7:0] A_TO_MU_MAP [128] = '{
		8'd1,   8'd3,   8'd5,   8'd7,   8'd9,   8'd11,  8'd13,  8'd15,
		8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,
		8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd31,
		8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd34,  8'd35,  8'd35,
		8'd36,  8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
		8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd48,  8'd49,  8'd49,
		8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,
		8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd64,
		8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,
		8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd80,
		8'd80,  8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,
		8'd88,  8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,
		8'd96,  8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103,
		8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111,
		8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
		8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127
	};

	// mu-law to a-law translation, entries are one above the a-law index
	localparam logic [7:0] MU_TO_A_MAP [128] = '{
		8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd4,
		8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,
		8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,
		8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,
		8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd34,  8'd35,  8'd36,
		8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,
		8'd46,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
		8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
		8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,
		8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
		8'd80,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,
		8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,  8'd96,
		8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
		8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
		8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
		8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	g711_in_t   req;
	logic       cfg_we;
	logic [2:0] cfg_wdata;
	logic       done;
	g711_out_t  rsp;

	g711_out_t   expected_samples[$];
	logic [2:0]  active_mode;
	bit          idle_on;
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned stall_cycles;

	g711_companding_codec_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// priority search for the segment, 8 when the magnitude is past the last one
	function automatic int unsigned segment_of(int unsigned mag);
		for (int s = 0; s < 8; s++) begin
			if (mag < (32'h100 << s))
				return s;
		end
		return 8;
	endfunction

	// linear to a-law with even-bit inversion
	function automatic logic [7:0] alaw_encode(logic [15:0] raw);
		int unsigned m;
		int unsigned mag;
		int unsigned seg;
		int unsigned code;
		logic [7:0]  flip;
		m = {16'h0, raw & 16'hFFF8};
		if (m[15]) begin
			flip = 8'h55;
			mag = 32'h10000 - m - 8;
		end else begin
			flip = 8'hD5;
			mag = m;
		end
		seg = segment_of(mag);
		if (seg >= 8)
			code = 32'h7F;
		else if (seg < 2)
			code = (seg << 4) | ((mag >> 4) & 32'hF);
		else
			code = (seg << 4) | ((mag >> (seg + 3)) & 32'hF);
		return code[7:0] ^ flip;
	endfunction

	// a-law back to linear
	function automatic logic [15:0] alaw_decode(logic [7:0] code);
		logic [7:0]  a;
		int unsigned seg;
		int unsigned t;
		a = code ^ 8'h55;
		seg = {29'd0, a[6:4]};
		t = {28'd0, a[3:0]} << 4;
		if (seg == 0)
			t = t + 32'h8;
		else if (seg == 1)
			t = t + 32'h108;
		else
			t = (t + 32'h108) << (seg - 1);
		return a[7] ? t[15:0] : 16'(32'd0 - t);
	endfunction

	// linear to mu-law: clip, bias, complement
	function automatic logic [7:0] ulaw_encode(logic [15:0] raw);
		int unsigned m;
		int unsigned mag;
		int unsigned seg;
		int unsigned code;
		logic [7:0]  flip;
		m = {16'h0, raw & 16'hFFFC};
		if (m[15]) begin
			flip = 8'h7F;
			mag = 32'h10000 - m;
		end else begin
			flip = 8'hFF;
			mag = m;
		end
		if (mag > 32636)
			mag = 32636;
		mag = mag + 32'h84;
		seg = segment_of(mag);
		if (seg >= 8)
			code = 32'h7F;
		else
			code = (seg << 4) | ((mag >> (seg + 3)) & 32'hF);
		return code[7:0] ^ flip;
	endfunction

	// mu-law back to linear
	function automatic logic [15:0] ulaw_decode(logic [7:0] code);
		logic [7:0]  u;
		int unsigned t;
		u = ~code;
		t = ({28'd0, u[3:0]} << 3) + 32'h84;
		t = t << u[6:4];
		return u[7] ? 16'(32'h84 - t) : 16'(t - 32'h84);
	endfunction

	function automatic logic [7:0] alaw_to_ulaw(logic [7:0] code);
		if (code[7])
			return 8'hFF ^ A_TO_MU_MAP[7'(code ^ 8'hD5)];
		return 8'h7F ^ A_TO_MU_MAP[7'(code ^ 8'h55)];
	endfunction

	function automatic logic [7:0] ulaw_to_alaw(logic [7:0] code);
		if (code[7])
			return 8'hD5 ^ (MU_TO_A_MAP[7'(8'hFF ^ code)] - 8'd1);
		return 8'h55 ^ (MU_TO_A_MAP[7'(8'h7F ^ code)] - 8'd1);
	endfunction

	// expected result of one sample in a given mode
	function automatic g711_out_t convert_sample(logic [2:0] md, g711_in_t s);
		g711_out_t r;
		r = '0;
		r.last_out = s.last_in;
		case (md)
			MODE_LIN2A:  r.code_out = alaw_encode(s.pcm_in);
			MODE_A2LIN:  r.pcm_out  = alaw_decode(s.code_in);
			MODE_LIN2MU: r.code_out = ulaw_encode(s.pcm_in);
			MODE_MU2LIN: r.pcm_out  = ulaw_decode(s.code_in);
			MODE_A2MU:   r.code_out = alaw_to_ulaw(s.code_in);
			MODE_MU2A:   r.code_out = ulaw_to_alaw(s.code_in);
			default: ;
		endcase
		return r;
	endfunction

	// random linear sample biased toward small values, segment edges and the clip region
	function automatic logic [15:0] random_pcm();
		logic [15:0] v;
		int unsigned k;
		case ($urandom_range(3))
			0: v = 16'($urandom_range(16'hFFFF));
			1: v = 16'($urandom_range(600));
			2: begin
				k = $urandom_range(7);
				v = 16'((32'h100 << k) + $urandom_range(16) - 8);
			end
			default: v = 16'(32'h7FFF - $urandom_range(300));
		endcase
		if ($urandom_range(1))
			v = 16'(0) - v;
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		// keep the log short when the block is badly broken
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
	endtask

	// send one request and record what it should produce
	task automatic send_sample(input logic [15:0] pcm, input logic [7:0] code, input logic last);
		g711_in_t s;
		s.pcm_in = pcm;
		s.code_in = code;
		s.last_in = last;
		// idle cycles drawn one at a time, about 28 in a hundred
		while (idle_on && $urandom_range(99) < 28) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_samples.push_back(convert_sample(active_mode, s));
	endtask

	task automatic send_random_sample();
		send_sample(random_pcm(), 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// stop sending and let every pending result come out
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_mode(input logic [2:0] md);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= md;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_mode = md;
	endtask

	// extremes, every mode, clipping and the corrected table entries
	task automatic test_directed();
		// reset mode is linear to a-law
		send_sample(16'h7FFF, 8'h00, 1'b0);
		send_sample(16'h8000, 8'hFF, 1'b1);
		send_sample(16'h0000, 8'hFF, 1'b0);
		send_sample(16'hFFFF, 8'h00, 1'b1);
		set_mode(MODE_LIN2MU);
		// clipped magnitudes, including the most negative sample
		send_sample(16'h7FFF, 8'h00, 1'b0);
		send_sample(16'h8000, 8'hFF, 1'b1);
		send_sample(16'd32636, 8'h00, 1'b0);
		send_sample(16'hFFF8, 8'hFF, 1'b1);
		set_mode(MODE_A2LIN);
		send_sample(16'h7FFF, 8'h00, 1'b1);
		send_sample(16'h8000, 8'hFF, 1'b0);
		set_mode(MODE_MU2LIN);
		send_sample(16'hFFFF, 8'h00, 1'b0);
		send_sample(16'h0000, 8'hFF, 1'b1);
		set_mode(MODE_A2MU);
		// positive code landing on a-to-mu entry 79
		send_sample(16'h0000, 8'h9A, 1'b0);
		send_sample(16'hFFFF, 8'h00, 1'b1);
		set_mode(MODE_MU2A);
		// positive code landing on mu-to-a entry 80, then a negative code at index 0
		send_sample(16'h0000, 8'hAF, 1'b1);
		send_sample(16'hFFFF, 8'h7F, 1'b0);
		set_mode(MODE_SPARE6);
		send_sample(16'h7FFF, 8'hFF, 1'b1);
		set_mode(MODE_SPARE7);
		send_sample(16'h8000, 8'h80, 1'b0);
	endtask

	task automatic test_alaw_encode();
		set_mode(MODE_LIN2A);
		repeat (110) send_random_sample();
	endtask

	task automatic test_alaw_decode();
		set_mode(MODE_A2LIN);
		repeat (100) send_random_sample();
	endtask

	task automatic test_ulaw_encode();
		set_mode(MODE_LIN2MU);
		repeat (110) send_random_sample();
	endtask

	task automatic test_ulaw_decode();
		set_mode(MODE_MU2LIN);
		repeat (100) send_random_sample();
	endtask

	task automatic test_law_translate();
		set_mode(MODE_A2MU);
		repeat (100) send_random_sample();
		set_mode(MODE_MU2A);
		repeat (100) send_random_sample();
	endtask

	task automatic test_unused_modes();
		set_mode(MODE_SPARE6);
		repeat (15) send_random_sample();
		set_mode(MODE_SPARE7);
		repeat (15) send_random_sample();
	endtask

	// random mode changes between short bursts
	task automatic test_mode_switching();
		repeat (8) begin
			set_mode(3'($urandom_range(7)));
			repeat ($urandom_range(10, 40)) send_random_sample();
		end
	endtask

	// one request every cycle with no gaps
	task automatic test_back_to_back();
		idle_on = 1'b0;
		set_mode(MODE_MU2LIN);
		repeat (60) send_random_sample();
		set_mode(MODE_LIN2MU);
		repeat (60) send_random_sample();
		idle_on = 1'b1;
	endtask

	// compare each result with the oldest pending sample
	always @(posedge clk) begin
		g711_out_t want;
		if (arst_n && done) begin
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("result %h with no request pending", rsp));
			end else begin
				want = expected_samples.pop_front();
				if (rsp.pcm_out !== want.pcm_out)
					report_mismatch($sformatf("pcm_out %0d, want %0d",
						rsp.pcm_out, want.pcm_out));
				if (rsp.code_out !== want.code_out)
					report_mismatch($sformatf("code_out %h, want %h",
						rsp.code_out, want.code_out));
				if (rsp.last_out !== want.last_out)
					report_mismatch($sformatf("last_out %b, want %b",
						rsp.last_out, want.last_out));
			end
			results_seen++;
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("g711_companding_codec_top verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		active_mode = MODE_LIN2A;
		idle_on = 1'b1;
		mismatches = 0;
		results_seen = 0;
		stall_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_alaw_encode();
		test_alaw_decode();
		test_ulaw_encode();
		test_ulaw_decode();
		test_law_translate();
		test_unused_modes();
		test_mode_switching();
		test_back_to_back();

		wait_drained();
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("g711_companding_codec_top verification clean");
		else
			$display("g711_companding_codec_top verification failed");
		$finish;
	end

endmodule
